/* rtl/adc_channel_register_model_core_assert.svh */
// Assertion macros for the converter register core.
`ifndef ADC_CHANNEL_REGISTER_MODEL_CORE_ASSERT_SVH
`define ADC_CHANNEL_REGISTER_MODEL_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property while out of reset.
`define ACRM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property at every edge, reset included.
`define ACRM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACRM_ASSERT(label, clk, rst, prop, msg)
`define ACRM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* rtl/acrm_pkg.sv */
package acrm_pkg;

   // Storage sizes
   localparam int REG_WORDS    = 256;
   localparam int NUM_CHANNELS = 8;
   localparam int ADDR_W       = $clog2(REG_WORDS);
   localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // Field widths
   localparam int DATA_W   = 32;
   localparam int INDEX_W  = 8;
   localparam int CHAN_W   = 3;
   localparam int SAMPLE_W = 12;

   // Register map
   localparam logic [INDEX_W-1:0] STATUS_WORD = 8'h01;
   localparam logic [INDEX_W-1:0] BUSY_WORD   = 8'h0F;
   localparam logic [INDEX_W-1:0] START_WORD  = 8'h15;

   localparam logic [DATA_W-1:0]   START_KEEP_MASK = 32'hFFFE_0000;
   localparam logic [DATA_W-1:0]   BUSY_KEEP_MASK  = ~32'h0000_00FF;
   localparam int                  DONE_START_BIT  = 16;
   localparam int                  DONE_STATUS_BIT = 15;
   localparam int                  SAMPLE_POS      = 16;
   localparam int                  PAD_SHIFT       = 19;
   localparam logic [SAMPLE_W-1:0] SAMPLE_RESET    = 12'd2048;

   // Bus commands
   typedef enum logic [1:0] {
      CMD_READ   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_SAMPLE = 2'd2
   } command_type;

   // Controller to datapath strobes
   typedef struct packed {
      logic fetch;
      logic write_en;
      logic sample_en;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic              found;
      logic [CHAN_W-1:0] channel;
   } pad_pick_type;

   // Lowest set pad-enable bit of a start word
   function automatic pad_pick_type pad_pick(input logic [DATA_W-1:0] data);
      pad_pick_type r;
      r = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (data[PAD_SHIFT + i]) begin
            r.found   = 1'b1;
            r.channel = CHAN_W'(i);
         end
      end
      return r;
   endfunction

endpackage

/* rtl/acrm_req_if.sv */
interface acrm_req_if;
   import acrm_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          command;
   logic [INDEX_W-1:0]  word_index;
   logic [DATA_W-1:0]   write_data;
   logic [CHAN_W-1:0]   channel_number;
   logic [SAMPLE_W-1:0] sample_value;

   modport source (
      output valid, command, word_index, write_data, channel_number, sample_value,
      input  ready
   );
   modport sink (
      input  valid, command, word_index, write_data, channel_number, sample_value,
      output ready
   );
endinterface

/* rtl/acrm_rsp_if.sv */
interface acrm_rsp_if;
   import acrm_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;

   modport source (
      output valid, read_data,
      input  ready
   );
   modport sink (
      input  valid, read_data,
      output ready
   );
endinterface

/* rtl/acrm_ctrl.sv */
module acrm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_command,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output acrm_pkg::ctrl_cmd_type cmd
);
   import acrm_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_ready && req_valid;
   assign rsp_valid = rsp_valid_ff;

   // Decode the transfer and sequence the read
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_READ: begin
                     cmd.fetch = 1'b1;
                     state_in  = ST_FETCH;
                  end
                  CMD_WRITE:  cmd.write_en  = 1'b1;
                  CMD_SAMPLE: cmd.sample_en = 1'b1;
                  default:    ;
               endcase
            end
         end
         ST_FETCH: begin
            // Load the output register once it is free or being drained
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

/* rtl/acrm_datapath.sv */
module acrm_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  acrm_pkg::ctrl_cmd_type        cmd,
   input  logic [acrm_pkg::INDEX_W-1:0]  word_index,
   input  logic [acrm_pkg::DATA_W-1:0]   write_data,
   input  logic [acrm_pkg::CHAN_W-1:0]   channel_number,
   input  logic [acrm_pkg::SAMPLE_W-1:0] sample_value,
   output logic [acrm_pkg::DATA_W-1:0]   read_data
);
   import acrm_pkg::*;

   logic [DATA_W-1:0]   mem [REG_WORDS];
   logic [REG_WORDS-1:0] written_ff, written_in;
   logic [SAMPLE_W-1:0] samples_ff [NUM_CHANNELS];
   logic [CHAN_W-1:0]   selected_ff, selected_in;
   logic [DATA_W-1:0]   rd_ff;
   logic                hit_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [DATA_W-1:0]   out_ff, out_in;
   logic [ADDR_W-1:0]   addr;
   logic                in_range;
   logic                ch_in_range;
   pad_pick_type        pad;
   logic [DATA_W-1:0]   stored;
   logic [DATA_W-1:0]   sample_word;

   assign addr        = ADDR_W'(word_index);
   assign in_range    = 32'(word_index) < REG_WORDS;
   assign ch_in_range = 32'(channel_number) < NUM_CHANNELS;
   assign pad         = pad_pick(write_data);

   // Mark written words; unwritten ones read as zero
   always_comb begin
      written_in = written_ff;
      if (cmd.write_en && in_range) begin
         written_in[addr] = 1'b1;
      end
   end

   // Take a new channel from a start write with a nonempty pad mask
   always_comb begin
      selected_in = selected_ff;
      if (cmd.write_en && word_index == START_WORD && pad.found) begin
         selected_in = pad.channel;
      end
   end

   // Register file: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.write_en && in_range) begin
         mem[addr] <= write_data;
      end
      if (cmd.fetch) begin
         rd_ff  <= mem[addr];
         hit_ff <= in_range && written_ff[addr];
         idx_ff <= word_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff  <= '0;
         selected_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            samples_ff[i] <= SAMPLE_RESET;
         end
      end else begin
         written_ff  <= written_in;
         selected_ff <= selected_in;
         if (cmd.sample_en && ch_in_range) begin
            samples_ff[CH_W'(channel_number)] <= sample_value;
         end
      end
   end

   // Build the read word from the fetched entry
   assign stored      = hit_ff ? rd_ff : '0;
   assign sample_word = DATA_W'(samples_ff[CH_W'(selected_ff)]);

   always_comb begin
      if (idx_ff == START_WORD) begin
         out_in = (stored & START_KEEP_MASK) | (DATA_W'(1) << DONE_START_BIT) | sample_word;
      end else if (idx_ff == STATUS_WORD) begin
         out_in = (sample_word << SAMPLE_POS) | (DATA_W'(1) << DONE_STATUS_BIT);
      end else if (idx_ff == BUSY_WORD) begin
         out_in = stored & BUSY_KEEP_MASK;
      end else begin
         out_in = stored;
      end
   end

   // Hold the result until the next load
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff <= out_in;
      end
   end

   assign read_data = out_ff;
endmodule

/* rtl/adc_channel_register_model_core.sv */
// Register-mapped converter core.
// The req channel carries bus commands: a register read, a register write,
// or a sample update for one converter channel. Only a read produces a
// transfer on the rsp channel, carrying the 32-bit read word.
// Writes and sample updates leave the controller idle, so they may follow
// one another in every cycle. A read latches the register file word at its
// acceptance edge, builds the read word in its fetch state and loads it
// into the output register once that register is free or being drained,
// which raises rsp valid. The next command is taken once that build step
// completes; the registered read port of the register file memory is what
// makes this separate build step necessary.
// The output register holds a finished word while the receiver stalls;
// the core keeps taking writes during that time, and a later read waits in
// its build step until the output register is drained.
// Reset marks every register word as unwritten (stored bits read as zero), sets
// every channel sample to mid-scale and selects channel zero. No clearing
// pass is needed: the core is ready in the cycle after reset falls.
`include "adc_channel_register_model_core_assert.svh"

module adc_channel_register_model_core (
   input logic        clock,
   input logic        reset,
   acrm_req_if.sink   req,
   acrm_rsp_if.source rsp
);
   import acrm_pkg::*;

   ctrl_cmd_type cmd;

   acrm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_command (req.command),
      .req_ready   (req.ready),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .cmd         (cmd)
   );

   acrm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .word_index     (req.word_index),
      .write_data     (req.write_data),
      .channel_number (req.channel_number),
      .sample_value   (req.sample_value),
      .read_data      (rsp.read_data)
   );

   // Checks on the controller strobes
   `ACRM_ASSERT(a_one_strobe, clock, reset, $onehot0(cmd), "more than one datapath strobe")
   `ACRM_ASSERT(a_load_valid, clock, reset, cmd.load_out |=> rsp.valid, "loaded word not shown")
   `ACRM_ASSERT(a_fetch_busy, clock, reset, cmd.fetch |=> !req.ready, "command taken in fetch")
   `ACRM_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp.valid && req.ready), "not idle")
endmodule

/* tb/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import acrm_pkg::*;

   localparam int RANDOM_OPS     = 1325;
   localparam int CALM_TAIL      = 150;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AFTER     = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;

   typedef struct packed {
      command_type         cmd;
      logic [INDEX_W-1:0]  index;
      logic [DATA_W-1:0]   wdata;
      logic [CHAN_W-1:0]   chan;
      logic [SAMPLE_W-1:0] sample;
   } bus_op_type;

   logic clock;
   logic reset;

   acrm_req_if req_ch ();
   acrm_rsp_if rsp_ch ();

   adc_channel_register_model_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Shadow copy of the converter registers
   logic [DATA_W-1:0]   shadow_regs [REG_WORDS];
   logic [SAMPLE_W-1:0] shadow_samples [NUM_CHANNELS];
   logic [CHAN_W-1:0]   shadow_channel;

   bus_op_type        bus_queue [$];
   logic [DATA_W-1:0] expected_reads [$];

   int   fail_count  = 0;
   int   reads_seen  = 0;
   int   idle_cycles = 0;
   logic calm_phase  = 1'b0;

   // Driver state
   int tx_cycles = 0;
   int gap_left  = 0;
   int gap_rate  = 0;

   // Receiver state
   int   rx_cycles  = 0;
   int   stall_left = 0;
   int   stall_rate = 0;
   int   hold_left  = 0;
   logic hold_done  = 1'b0;

   // Word seen on a read of the given address
   function automatic logic [DATA_W-1:0] read_view(logic [INDEX_W-1:0] idx);
      logic [DATA_W-1:0] smp;
      smp = DATA_W'(shadow_samples[shadow_channel]);
      if (idx == START_WORD)
         return (shadow_regs[idx] & START_KEEP_MASK) | (DATA_W'(1) << DONE_START_BIT) | smp;
      if (idx == STATUS_WORD)
         return (smp << SAMPLE_POS) | (DATA_W'(1) << DONE_STATUS_BIT);
      if (idx == BUSY_WORD)
         return shadow_regs[idx] & BUSY_KEEP_MASK;
      return shadow_regs[idx];
   endfunction

   // Advance the shadow state by one bus command, queue the read word if any
   task automatic predict_bus_op(input logic [1:0] cmd, input logic [INDEX_W-1:0] idx,
                                 input logic [DATA_W-1:0] data, input logic [CHAN_W-1:0] ch,
                                 input logic [SAMPLE_W-1:0] smp);
      logic found;
      found = 1'b0;
      if (cmd == CMD_READ) begin
         expected_reads.push_back(read_view(idx));
      end else if (cmd == CMD_WRITE) begin
         shadow_regs[idx] = data;
         if (idx == START_WORD) begin
            // lowest pad-enable bit wins; an empty mask keeps the old channel
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               if (!found && data[PAD_SHIFT + i]) begin
                  shadow_channel = CHAN_W'(i);
                  found = 1'b1;
               end
            end
         end
      end else if (cmd == CMD_SAMPLE) begin
         if (ch < NUM_CHANNELS)
            shadow_samples[ch] = smp;
      end
   endtask

   function automatic bus_op_type make_op(command_type cmd, logic [INDEX_W-1:0] idx,
                                          logic [DATA_W-1:0] data, logic [CHAN_W-1:0] ch,
                                          logic [SAMPLE_W-1:0] smp);
      bus_op_type op;
      op.cmd    = cmd;
      op.index  = idx;
      op.wdata  = data;
      op.chan   = ch;
      op.sample = smp;
      return op;
   endfunction

   function automatic bus_op_type random_op();
      bus_op_type op;
      int         pick;
      pick = $urandom_range(0, 99);
      op.cmd = (pick < 35) ? CMD_READ : (pick < 75) ? CMD_WRITE : CMD_SAMPLE;
      case ($urandom_range(0, 9))
         0:       op.index = STATUS_WORD;
         1:       op.index = BUSY_WORD;
         2, 3:    op.index = START_WORD;
         4:       op.index = '0;
         5:       op.index = INDEX_W'(REG_WORDS - 1);
         default: op.index = INDEX_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0:       op.wdata = '0;
         1:       op.wdata = '1;
         default: op.wdata = $urandom;
      endcase
      // shape the pad-enable field: empty, one-hot, or left random
      case ($urandom_range(0, 3))
         0:       op.wdata[PAD_SHIFT +: NUM_CHANNELS] = '0;
         1:       op.wdata[PAD_SHIFT +: NUM_CHANNELS] = NUM_CHANNELS'(1) << $urandom_range(0, 7);
         default: ;
      endcase
      op.chan = CHAN_W'($urandom);
      case ($urandom_range(0, 4))
         0:       op.sample = '0;
         1:       op.sample = '1;
         default: op.sample = SAMPLE_W'($urandom);
      endcase
      return op;
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Reset, stimulus and end of run
   initial begin
      bus_op_type op;
      bus_op_type op2;
      int         target;
      reset              = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.command        = CMD_READ;
      req_ch.word_index     = '0;
      req_ch.write_data     = '0;
      req_ch.channel_number = '0;
      req_ch.sample_value   = '0;
      rsp_ch.ready          = 1'b0;
      for (int i = 0; i < REG_WORDS; i++) shadow_regs[i] = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) shadow_samples[i] = SAMPLE_RESET;
      shadow_channel = '0;

      // Directed: reset view, masks, pad selection, sample extremes
      bus_queue.push_back(make_op(CMD_READ, STATUS_WORD, '0, '0, '0));
      bus_queue.push_back(make_op(CMD_READ, START_WORD, '0, '0, '0));
      bus_queue.push_back(make_op(CMD_READ, BUSY_WORD, '0, '0, '0));
      bus_queue.push_back(make_op(CMD_WRITE, BUSY_WORD, '1, '0, '0));
      bus_queue.push_back(make_op(CMD_READ, BUSY_WORD, '0, '0, '0));
      bus_queue.push_back(make_op(CMD_WRITE, '0, '1, '1, '1));
      bus_queue.push_back(make_op(CMD_READ, '0, '0, '0, '0));
      bus_queue.push_back(make_op(CMD_WRITE, '1, 32'hA5A5_5A5A, '0, '0));
      bus_queue.push_back(make_op(CMD_READ, '1, '0, '0, '0));
      bus_queue.push_back(make_op(CMD_READ, 8'hFE, '0, '0, '0));
      bus_queue.push_back(make_op(CMD_SAMPLE, '0, '0, 3'd7, '1));
      bus_queue.push_back(make_op(CMD_SAMPLE, '0, '0, 3'd0, '0));
      bus_queue.push_back(make_op(CMD_WRITE, START_WORD, 32'h0400_FFFF, '0, '0));
      bus_queue.push_back(make_op(CMD_READ, START_WORD, '0, '0, '0));
      bus_queue.push_back(make_op(CMD_WRITE, START_WORD, '0, '0, '0));
      bus_queue.push_back(make_op(CMD_READ, STATUS_WORD, '0, '0, '0));
      bus_queue.push_back(make_op(CMD_WRITE, START_WORD, 32'hFFF8_0000, '0, '0));
      bus_queue.push_back(make_op(CMD_READ, START_WORD, '0, '0, '0));
      bus_queue.push_back(make_op(CMD_WRITE, STATUS_WORD, '1, '0, '0));
      bus_queue.push_back(make_op(CMD_READ, STATUS_WORD, '0, '0, '0));
      bus_queue.push_back(make_op(CMD_SAMPLE, '0, '0, 3'd3, 12'hABC));
      bus_queue.push_back(make_op(CMD_WRITE, START_WORD, 32'h0040_0000, '0, '0));
      bus_queue.push_back(make_op(CMD_READ, START_WORD, '0, '0, '0));
      bus_queue.push_back(make_op(CMD_READ, STATUS_WORD, '0, '0, '0));

      // Random: single commands, write/read-back pairs, sample-start-read runs
      target = bus_queue.size() + RANDOM_OPS;
      while (bus_queue.size() < target) begin
         op = random_op();
         case ($urandom_range(0, 3))
            0, 1: bus_queue.push_back(op);
            2: begin
               op.cmd = CMD_WRITE;
               bus_queue.push_back(op);
               op.cmd   = CMD_READ;
               op.wdata = $urandom;
               bus_queue.push_back(op);
            end
            default: begin
               op.cmd = CMD_SAMPLE;
               bus_queue.push_back(op);
               op2       = random_op();
               op2.cmd   = CMD_WRITE;
               op2.index = START_WORD;
               bus_queue.push_back(op2);
               op2       = random_op();
               op2.cmd   = CMD_READ;
               op2.index = $urandom_range(0, 1) ? START_WORD : STATUS_WORD;
               bus_queue.push_back(op2);
            end
         endcase
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Wait for every command and every read word to go through
      do @(negedge clock);
      while (bus_queue.size() != 0 || req_ch.valid || expected_reads.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Driver: offer queued commands with random gaps
   always @(posedge clock) begin
      bus_op_type op;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         tx_cycles  <= tx_cycles + 1;
         calm_phase <= (bus_queue.size() < CALM_TAIL);
         if (tx_cycles % 96 == 0) gap_rate <= $urandom_range(0, 3);
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left     <= gap_left - 1;
               req_ch.valid <= 1'b0;
            end else if (bus_queue.size() > 0) begin
               op = bus_queue.pop_front();
               req_ch.valid          <= 1'b1;
               req_ch.command        <= op.cmd;
               req_ch.word_index     <= op.index;
               req_ch.write_data     <= op.wdata;
               req_ch.channel_number <= op.chan;
               req_ch.sample_value   <= op.sample;
               if (!calm_phase && gap_rate != 0 && $urandom_range(0, 15) < gap_rate * 2)
                  gap_left <= $urandom_range(1, 14);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls plus one long hold-off to back up the core
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rx_cycles <= rx_cycles + 1;
         if (rx_cycles % 80 == 0) stall_rate <= $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && reads_seen >= HOLD_AFTER) begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!calm_phase && stall_rate != 0 && $urandom_range(0, 15) < stall_rate) begin
            stall_left   <= $urandom_range(1, 14) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Monitor: predict on each command transfer, check each read word transfer
   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            predict_bus_op(req_ch.command, req_ch.word_index, req_ch.write_data,
                           req_ch.channel_number, req_ch.sample_value);
         if (rsp_ch.valid && rsp_ch.ready) begin
            reads_seen <= reads_seen + 1;
            if (expected_reads.size() == 0) begin
               $display("%0t: unexpected read word: expected none, actual %h",
                        $time, rsp_ch.read_data);
               fail_count++;
            end else begin
               want = expected_reads.pop_front();
               if (rsp_ch.read_data !== want) begin
                  $display("%0t: read_data mismatch: expected %h, actual %h",
                           $time, want, rsp_ch.read_data);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/acrm_pkg.sv
rtl/acrm_req_if.sv
rtl/acrm_rsp_if.sv
rtl/acrm_ctrl.sv
rtl/acrm_datapath.sv
rtl/adc_channel_register_model_core.sv
tb/tb.sv
